FILE: hdl/ptd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and codes for the periodic timer dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int RESULT_CAP = 16;
	localparam int CNT_W      = 5;

	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_SCHED  = 2'd1;
	localparam logic [1:0] FUNC_CANCEL = 2'd2;

	localparam logic [1:0] KIND_ID     = 2'd0;
	localparam logic [1:0] KIND_DISP   = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;
	localparam logic [1:0] KIND_FULL   = 2'd3;

	typedef struct packed {
		logic [31:0] deadline;
		logic [15:0] period;
		logic [15:0] remaining;
		logic [7:0]  prio;
		logic [15:0] ident;
		logic [15:0] tag;
	} rec_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic tick;
		logic scan_start;
		logic scan_run;
		logic match_cancel;
		logic decide;
		logic flush;
		logic sched;
		logic cancel_done;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic best_found;
		logic cnt_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

FILE: hdl/ptd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ptd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                           clk,
	input  wire                           we,
	input  wire [$clog2(DEPTH)-1:0]       waddr,
	input  wire [WIDTH-1:0]               wdata,
	input  wire [$clog2(DEPTH)-1:0]       raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: hdl/ptd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_ctrl
// Controller state machine: sequences ticks, table scans, schedule and cancel.
// ----------------------------------------------------------------------------
module ptd_ctrl import ptd_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [1:0]  func,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_TICK   = 9'b000000010,
		S_TSTART = 9'b000000100,
		S_TSCAN  = 9'b000001000,
		S_DECIDE = 9'b000010000,
		S_FLUSH  = 9'b000100000,
		S_SCHED  = 9'b001000000,
		S_CSTART = 9'b010000000,
		S_CSCAN  = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   cend_q, cend_d;

	always_comb begin
		state_d  = state_q;
		cend_d   = cend_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (func)
						FUNC_TICK:   state_d = S_TICK;
						FUNC_SCHED:  state_d = S_SCHED;
						FUNC_CANCEL: state_d = S_CSTART;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_TICK: begin
				cmd.tick       = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = S_TSCAN;
			end
			S_TSTART: begin
				cmd.scan_start = 1'b1;
				state_d        = S_TSCAN;
			end
			S_TSCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.out_free) begin
					cmd.decide = 1'b1;
					if (!sts.best_found) begin
						state_d = S_IDLE;
					end else if (sts.cnt_last) begin
						state_d = S_FLUSH;
					end else begin
						state_d = S_TSTART;
					end
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_SCHED: begin
				if (sts.out_free) begin
					cmd.sched = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_CSTART: begin
				cmd.scan_start = 1'b1;
				cend_d         = 1'b0;
				state_d        = S_CSCAN;
			end
			S_CSCAN: begin
				cmd.match_cancel = 1'b1;
				if (!cend_q) begin
					cmd.scan_run = 1'b1;
					if (sts.scan_done) begin
						cend_d = 1'b1;
					end
				end else if (sts.out_free) begin
					cmd.cancel_done = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cend_q  <= cend_d;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/ptd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_dp
// Datapath: timer table, sequential scan with best-candidate register,
// dispatch holding register, worker rotation and result register.
// ----------------------------------------------------------------------------
module ptd_dp import ptd_pkg::*; #(
	parameter int TIMER_SLOTS = 16,
	parameter int WORKER_MAX  = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  wire [15:0] delay,
	input  wire [15:0] interval,
	input  wire [15:0] repeat_count,
	input  wire [7:0]  priority_req,
	input  wire [15:0] task_tag,
	input  wire [15:0] cancel_id,
	input  wire        cfg_we,
	input  wire [2:0]  cfg_wdata,
	input  wire        out_ready,
	output logic       out_valid,
	output logic [1:0] kind,
	output logic [15:0] timer_id,
	output logic [15:0] tag_out,
	output logic [1:0] worker,
	output logic       found,
	output logic       last
);

	localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = SW + 1;
	localparam int PW = (WORKER_MAX > 1) ? $clog2(WORKER_MAX) : 1;
	localparam int RW = $bits(rec_t);

	logic [31:0] time_q;
	logic [15:0] id_q;
	logic [PW-1:0] rot_q;
	logic [2:0]  wc_q;
	logic [TIMER_SLOTS-1:0] valid_q;

	logic [15:0] delay_q, interval_q, repeat_q, tag_q, cid_q;
	logic [7:0]  prio_q;

	logic [CW-1:0] rd_cnt_q;
	logic          vld_s1;
	logic [SW-1:0] idx_s1;

	logic          best_found_q;
	logic [SW-1:0] best_idx_q;
	rec_t          best_rec_q;
	logic [31:0]   best_age_q;

	logic [CNT_W-1:0] cnt_q;
	logic          pend_q;
	logic [15:0]   pend_id_q, pend_tag_q;
	logic [1:0]    pend_wk_q;

	rec_t          rd_rec;
	logic [RW-1:0] rd_raw;
	logic [31:0]   age;
	logic          due, better, hit, issue;
	logic          free_any;
	logic [SW-1:0] free_idx;
	logic [15:0]   id_inc, id_nxt;
	logic [4:0]    n5, r5, w5, w5_inc, nxt5;
	rec_t          wb_rec, sc_rec;
	logic          free_best;
	logic          ram_we;
	logic [SW-1:0] ram_waddr;
	rec_t          ram_wdata;
	logic          out_free, out_load;

	ptd_ram #(
		.WIDTH (RW),
		.DEPTH (TIMER_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_cnt_q[SW-1:0]),
		.rdata (rd_raw)
	);

	assign rd_rec = rec_t'(rd_raw);
	assign age    = time_q - rd_rec.deadline;
	assign due    = valid_q[idx_s1] && !age[31];
	assign better = !best_found_q || (age > best_age_q) ||
	                ((age == best_age_q) && ((rd_rec.prio > best_rec_q.prio) ||
	                 ((rd_rec.prio == best_rec_q.prio) &&
	                  (rd_rec.ident < best_rec_q.ident))));
	assign hit    = valid_q[idx_s1] && (rd_rec.ident == cid_q);
	assign issue  = rd_cnt_q < CW'(TIMER_SLOTS);

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	// ids wrap and skip zero
	assign id_inc = id_q + 16'd1;
	assign id_nxt = (id_inc == 16'd0) ? 16'd1 : id_inc;

	// worker rotation with clamped count
	always_comb begin
		if (wc_q == 3'd0) begin
			n5 = 5'd1;
		end else if ({2'b00, wc_q} > 5'(WORKER_MAX)) begin
			n5 = 5'(WORKER_MAX);
		end else begin
			n5 = {2'b00, wc_q};
		end
		r5     = 5'(rot_q);
		w5     = (r5 >= n5) ? 5'd0 : r5;
		w5_inc = w5 + 5'd1;
		nxt5   = (w5_inc >= n5) ? 5'd0 : w5_inc;
	end

	always_comb begin
		wb_rec          = best_rec_q;
		wb_rec.deadline = time_q + {16'd0, best_rec_q.period};
		if (best_rec_q.remaining > 16'd1) begin
			wb_rec.remaining = best_rec_q.remaining - 16'd1;
		end
		free_best = best_rec_q.remaining == 16'd1;

		sc_rec.deadline  = time_q + {16'd0, delay_q};
		sc_rec.period    = (interval_q == 16'd0) ? 16'd1 : interval_q;
		sc_rec.remaining = repeat_q;
		sc_rec.prio      = prio_q;
		sc_rec.ident     = id_nxt;
		sc_rec.tag       = tag_q;
	end

	assign ram_we    = (cmd.sched && free_any) ||
	                   (cmd.decide && best_found_q && !free_best);
	assign ram_waddr = cmd.sched ? free_idx : best_idx_q;
	assign ram_wdata = cmd.sched ? sc_rec : wb_rec;

	assign out_free = !out_valid || out_ready;
	assign out_load = (cmd.decide && pend_q) || cmd.flush || cmd.sched || cmd.cancel_done;

	assign sts.scan_done  = (rd_cnt_q == CW'(TIMER_SLOTS)) && !vld_s1;
	assign sts.best_found = best_found_q;
	assign sts.cnt_last   = cnt_q == CNT_W'(RESULT_CAP - 1);
	assign sts.out_free   = out_free;

	// item fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			delay_q    <= delay;
			interval_q <= interval;
			repeat_q   <= repeat_count;
			prio_q     <= priority_req;
			tag_q      <= task_tag;
			cid_q      <= cancel_id;
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (cmd.scan_run) begin
			idx_s1 <= rd_cnt_q[SW-1:0];
			if (vld_s1 && !cmd.match_cancel && due && better) begin
				best_idx_q <= idx_s1;
				best_rec_q <= rd_rec;
				best_age_q <= age;
			end
			if (vld_s1 && cmd.match_cancel && hit && !best_found_q) begin
				best_idx_q <= idx_s1;
			end
		end
		if (cmd.decide && best_found_q) begin
			pend_id_q  <= best_rec_q.ident;
			pend_tag_q <= best_rec_q.tag;
			pend_wk_q  <= w5[1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q       <= '0;
			id_q         <= '0;
			rot_q        <= '0;
			wc_q         <= 3'd4;
			valid_q      <= '0;
			rd_cnt_q     <= '0;
			vld_s1       <= 1'b0;
			best_found_q <= 1'b0;
			cnt_q        <= '0;
			pend_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				wc_q <= cfg_wdata;
			end
			if (cmd.tick) begin
				time_q <= time_q + 32'd1;
				cnt_q  <= '0;
				pend_q <= 1'b0;
			end
			if (cmd.scan_start) begin
				rd_cnt_q     <= '0;
				vld_s1       <= 1'b0;
				best_found_q <= 1'b0;
			end else if (cmd.scan_run) begin
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + CW'(1);
				end
				vld_s1 <= issue;
				if (vld_s1 && !cmd.match_cancel && due) begin
					best_found_q <= 1'b1;
				end
				if (vld_s1 && cmd.match_cancel && hit) begin
					best_found_q <= 1'b1;
				end
			end
			if (cmd.decide) begin
				pend_q <= best_found_q;
				if (best_found_q) begin
					rot_q <= nxt5[PW-1:0];
					cnt_q <= cnt_q + CNT_W'(1);
					if (free_best) begin
						valid_q[best_idx_q] <= 1'b0;
					end
				end
			end
			if (cmd.flush) begin
				pend_q <= 1'b0;
			end
			if (cmd.sched) begin
				if (free_any) begin
					valid_q[free_idx] <= 1'b1;
					id_q              <= id_nxt;
				end
			end
			if (cmd.cancel_done && best_found_q) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.decide && pend_q) begin
			kind     <= KIND_DISP;
			timer_id <= pend_id_q;
			tag_out  <= pend_tag_q;
			worker   <= pend_wk_q;
			found    <= 1'b0;
			last     <= !best_found_q;
		end else if (cmd.flush) begin
			kind     <= KIND_DISP;
			timer_id <= pend_id_q;
			tag_out  <= pend_tag_q;
			worker   <= pend_wk_q;
			found    <= 1'b0;
			last     <= 1'b1;
		end else if (cmd.sched) begin
			kind     <= free_any ? KIND_ID : KIND_FULL;
			timer_id <= free_any ? id_nxt : 16'd0;
			tag_out  <= 16'd0;
			worker   <= 2'd0;
			found    <= 1'b0;
			last     <= 1'b1;
		end else if (cmd.cancel_done) begin
			kind     <= KIND_CANCEL;
			timer_id <= cid_q;
			tag_out  <= 16'd0;
			worker   <= 2'd0;
			found    <= best_found_q;
			last     <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("result loaded over a waiting item");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(RESULT_CAP)) else $error("dispatch count over cap");
	a_no_wr_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !cmd.scan_run) else $error("table write during scan");
	a_pend_disp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> pend_q) else $error("flush without pending dispatch");
`endif

endmodule
`default_nettype wire

FILE: hdl/periodic_timer_dispatcher_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_dispatcher_core
// Timer table with schedule, cancel and tick-driven ordered dispatch.
// ----------------------------------------------------------------------------
// One item is handled at a time. Cancel and each dispatch pass of a tick read
// the whole table through one RAM read port; a tick takes one pass per
// dispatch plus one final pass that finds nothing, or 16 passes and no final
// pass when the dispatch cap is reached, and a tick with nothing due one pass.
// Results wait in an output register; a stalled output holds the sequencer.
module periodic_timer_dispatcher_core import ptd_pkg::*; #(
	parameter int TIMER_SLOTS = 16,
	parameter int WORKER_MAX  = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire [1:0]   func,
	input  wire [15:0]  delay,
	input  wire [15:0]  interval,
	input  wire [15:0]  repeat_count,
	input  wire [7:0]   priority_req,
	input  wire [15:0]  task_tag,
	input  wire [15:0]  cancel_id,
	input  wire         cfg_we,
	input  wire [2:0]   cfg_wdata,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  kind,
	output logic [15:0] timer_id,
	output logic [15:0] tag_out,
	output logic [1:0]  worker,
	output logic        found,
	output logic        last
);

	cmd_t cmd;
	sts_t sts;

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptd_dp #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.WORKER_MAX  (WORKER_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.delay        (delay),
		.interval     (interval),
		.repeat_count (repeat_count),
		.priority_req (priority_req),
		.task_tag     (task_tag),
		.cancel_id    (cancel_id),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.kind         (kind),
		.timer_id     (timer_id),
		.tag_out      (tag_out),
		.worker       (worker),
		.found        (found),
		.last         (last)
	);

endmodule
`default_nettype wire

FILE: dv/periodic_timer_dispatcher_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_dispatcher_core_tb
// Drives schedule, cancel and tick items into the timer dispatcher, predicts
// every id, cancel answer and ordered dispatch, and checks each result item.
// ----------------------------------------------------------------------------
module periodic_timer_dispatcher_core_tb;
	import ptd_pkg::*;

	localparam int SLOTS = 16;
	localparam int WMAX  = 4;
	localparam longint LIMIT = 3000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] timer_id;
		logic [15:0] tag_out;
		logic [1:0]  worker;
		logic        found;
		logic        last;
	} res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [15:0] delay;
	logic [15:0] interval;
	logic [15:0] repeat_count;
	logic [7:0]  priority_req;
	logic [15:0] task_tag;
	logic [15:0] cancel_id;
	logic        cfg_we;
	logic [2:0]  cfg_wdata;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [15:0] timer_id;
	logic [15:0] tag_out;
	logic [1:0]  worker;
	logic        found;
	logic        last;

	// predictor state
	logic [31:0] now_ms;
	logic        live [SLOTS];
	rec_t        slot_rec [SLOTS];
	logic [15:0] next_id;
	int unsigned rr_ptr;
	logic [2:0]  workers_cfg;

	res_t        pending_results [$];
	int          errors;
	int          checked;
	int          dispatches;
	longint      cycles;
	bit          rx_idle_on;
	bit          tx_idle_on;
	int          hold_off;

	periodic_timer_dispatcher_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.delay        (delay),
		.interval     (interval),
		.repeat_count (repeat_count),
		.priority_req (priority_req),
		.task_tag     (task_tag),
		.cancel_id    (cancel_id),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.timer_id     (timer_id),
		.tag_out      (tag_out),
		.worker       (worker),
		.found        (found),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input res_t got, input res_t exp);
		errors++;
		$display("mismatch %s: got k%0d id%0d tag%0d w%0d f%0d l%0d exp k%0d id%0d tag%0d w%0d f%0d l%0d",
			what, got.kind, got.timer_id, got.tag_out, got.worker, got.found, got.last,
			exp.kind, exp.timer_id, exp.tag_out, exp.worker, exp.found, exp.last);
	endtask

	function automatic bit due_first(int a, int b);
		logic [31:0] age_a, age_b;
		age_a = now_ms - slot_rec[a].deadline;
		age_b = now_ms - slot_rec[b].deadline;
		if (age_a != age_b) return age_a > age_b;
		if (slot_rec[a].prio != slot_rec[b].prio) return slot_rec[a].prio > slot_rec[b].prio;
		if (slot_rec[a].ident != slot_rec[b].ident) return slot_rec[a].ident < slot_rec[b].ident;
		return a < b;
	endfunction

	function automatic int unsigned pick_worker();
		int unsigned n, w;
		n = workers_cfg;
		if (n == 0) n = 1;
		if (n > WMAX) n = WMAX;
		if (rr_ptr >= n) rr_ptr = 0;
		w = rr_ptr;
		rr_ptr = (rr_ptr + 1 >= n) ? 0 : rr_ptr + 1;
		return w;
	endfunction

	// work out the result items of one accepted item
	task automatic predict_item(input logic [1:0] f, input logic [15:0] dl,
			input logic [15:0] iv, input logic [15:0] rc, input logic [7:0] pr,
			input logic [15:0] tg, input logic [15:0] cid);
		res_t r;
		res_t batch [$];
		int best, slot;
		batch = {};
		if (f == FUNC_TICK) begin
			now_ms = now_ms + 1;
			while (batch.size() < RESULT_CAP) begin
				best = -1;
				for (int i = 0; i < SLOTS; i++) begin
					if (!live[i]) continue;
					if (((now_ms - slot_rec[i].deadline) & 32'h8000_0000) != 0) continue;
					if (best < 0 || due_first(i, best)) best = i;
				end
				if (best < 0) break;
				r = '0;
				r.kind = KIND_DISP;
				r.timer_id = slot_rec[best].ident;
				r.tag_out = slot_rec[best].tag;
				r.worker = 2'(pick_worker());
				batch.push_back(r);
				if (slot_rec[best].remaining == 1) begin
					live[best] = 1'b0;
				end else begin
					if (slot_rec[best].remaining > 1)
						slot_rec[best].remaining--;
					slot_rec[best].deadline = now_ms + 32'(slot_rec[best].period);
				end
			end
		end else if (f == FUNC_SCHED) begin
			slot = -1;
			for (int i = 0; i < SLOTS; i++) begin
				if (!live[i]) begin
					slot = i;
					break;
				end
			end
			r = '0;
			if (slot < 0) begin
				r.kind = KIND_FULL;
			end else begin
				next_id = next_id + 1;
				if (next_id == 0) next_id = 1;
				live[slot] = 1'b1;
				slot_rec[slot].deadline = now_ms + 32'(dl);
				slot_rec[slot].period = (iv == 0) ? 16'd1 : iv;
				slot_rec[slot].remaining = rc;
				slot_rec[slot].prio = pr;
				slot_rec[slot].tag = tg;
				slot_rec[slot].ident = next_id;
				r.kind = KIND_ID;
				r.timer_id = next_id;
			end
			batch.push_back(r);
		end else if (f == FUNC_CANCEL) begin
			r = '0;
			r.kind = KIND_CANCEL;
			r.timer_id = cid;
			for (int i = 0; i < SLOTS; i++) begin
				if (live[i] && slot_rec[i].ident == cid) begin
					live[i] = 1'b0;
					r.found = 1'b1;
					break;
				end
			end
			batch.push_back(r);
		end
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) pending_results.push_back(batch[i]);
	endtask

	// sends one item, idling first at random; valid stays up for a following item
	task automatic send_item(input logic [1:0] f, input logic [15:0] dl = 0,
			input logic [15:0] iv = 0, input logic [15:0] rc = 0, input logic [7:0] pr = 0,
			input logic [15:0] tg = 0, input logic [15:0] cid = 0);
		while (tx_idle_on && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		delay <= dl;
		interval <= iv;
		repeat_count <= rc;
		priority_req <= pr;
		task_tag <= tg;
		cancel_id <= cid;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(f, dl, iv, rc, pr, tg, cid);
	endtask

	task automatic send_random_schedule(input bit short_delay);
		send_item(FUNC_SCHED, short_delay ? 16'($urandom_range(4)) : 16'($urandom),
			$urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(5)),
			$urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(4)),
			8'($urandom_range(3) == 0 ? $urandom : $urandom_range(2)), 16'($urandom));
	endtask

	// waits for all expected results, plus the slow empty-scan tail
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SLOTS * 3 + 20) @(posedge clk);
	endtask

	task automatic write_workers(input logic [2:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		workers_cfg = v;
	endtask

	task automatic test_basic_ops();
		send_item(FUNC_TICK);
		send_item(FUNC_SCHED, 16'd0, 16'd0, 16'd2, 8'd0, 16'hFFFF);
		send_item(FUNC_SCHED, 16'd1, 16'd3, 16'd0, 8'hFF, 16'h0000);
		send_item(FUNC_SCHED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h80, 16'hA5A5);
		send_item(FUNC_TICK);
		send_item(FUNC_TICK);
		send_item(FUNC_CANCEL, .cid(16'd3));
		send_item(FUNC_CANCEL, .cid(16'd3));
		send_item(FUNC_CANCEL, .cid(16'hFFFF));
		send_item(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_item(FUNC_TICK);
		send_item(FUNC_CANCEL, .cid(16'd2));
		drain();
	endtask

	// same deadline, ties broken by priority then id; then table full
	task automatic test_full_table();
		for (int i = 0; i < SLOTS; i++)
			send_item(FUNC_SCHED, 16'd2, 16'd1, 16'd0, 8'(i % 3), 16'(i));
		send_item(FUNC_SCHED, 16'd1, 16'd1, 16'd1, 8'd1, 16'd1);
		send_item(FUNC_TICK);
		send_item(FUNC_TICK);
		send_item(FUNC_TICK);
		drain();
		for (int i = 0; i < SLOTS; i++)
			send_item(FUNC_CANCEL, .cid(16'(next_id - i)));
		drain();
	endtask

	// long output hold-off while items keep coming
	task automatic test_backpressure();
		hold_off = 400;
		for (int i = 0; i < 8; i++) send_random_schedule(1'b1);
		for (int i = 0; i < 6; i++) send_item(FUNC_TICK);
		drain();
	endtask

	task automatic test_worker_settings();
		logic [2:0] settings [5] = '{3'd1, 3'd0, 3'd7, 3'd3, 3'd2};
		foreach (settings[s]) begin
			write_workers(settings[s]);
			for (int i = 0; i < 5; i++) send_item(FUNC_TICK);
			drain();
		end
		write_workers(3'd4);
	endtask

	task automatic test_random_mix(input int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			if (i == n / 3) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			if (i == n / 2) begin
				tx_idle_on = 1'b1;
				rx_idle_on = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 40) send_random_schedule($urandom_range(3) != 0);
			else if (pick < 80) send_item(FUNC_TICK);
			else if (pick < 95)
				send_item(FUNC_CANCEL, .cid($urandom_range(1) ? 16'($urandom_range(next_id + 2))
					: 16'($urandom)));
			else send_item(2'd3, 16'($urandom), 16'($urandom), 16'($urandom),
				8'($urandom), 16'($urandom), 16'($urandom));
		end
		drain();
	endtask

	// receiver side
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(rx_idle_on && $urandom_range(99) < 29);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		res_t got, exp;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind, timer_id, tag_out, worker, found, last};
			checked++;
			if (kind == KIND_DISP) dispatches++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected", got, '0);
			end else begin
				exp = pending_results.pop_front();
				if (got !== exp) report_mismatch("field", got, exp);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("periodic_timer_dispatcher_core_tb NOT OK");
			$finish;
		end
	end

	initial begin
		errors = 0;
		checked = 0;
		dispatches = 0;
		cycles = 0;
		hold_off = 0;
		rx_idle_on = 1'b1;
		tx_idle_on = 1'b1;
		now_ms = '0;
		next_id = '0;
		rr_ptr = 0;
		workers_cfg = 3'd4;
		foreach (live[i]) live[i] = 1'b0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		func <= '0;
		delay <= '0;
		interval <= '0;
		repeat_count <= '0;
		priority_req <= '0;
		task_tag <= '0;
		cancel_id <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_full_table();
		test_backpressure();
		test_worker_settings();
		test_random_mix(45);
		if (pending_results.size() != 0) begin
			errors++;
			$display("%0d results never arrived", pending_results.size());
		end
		$display("covered schedule, cancel, tick dispatch order, full table, output stalls");
		$display("and worker counts inside and outside the usual range");
		$display("%0d result items checked, %0d dispatches, %0d errors", checked, dispatches, errors);
		if (errors == 0) begin
			$display("periodic_timer_dispatcher_core_tb OK");
		end else begin
			$display("periodic_timer_dispatcher_core_tb NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: periodic_timer_dispatcher_core.f
hdl/ptd_pkg.sv
hdl/ptd_ram.sv
hdl/ptd_ctrl.sv
hdl/ptd_dp.sv
hdl/periodic_timer_dispatcher_core.sv
dv/periodic_timer_dispatcher_core_tb.sv
